[sv/fpfa_pkg.sv]
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared constants and types for the fixed partition fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpfa_pkg;

  localparam int NumBlocks = 16;
  localparam int BlkIdxW   = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int CntW      = $clog2(NumBlocks + 1);

  localparam int OpW       = 2;
  localparam int BlockW    = 4;
  localparam int SizeW     = 16;
  localparam int OwnerW    = 8;
  localparam int FitW      = 2;
  localparam int InUseW    = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 5;

  typedef enum logic [OpW-1:0] {
    OpLoad  = 2'd0,
    OpAlloc = 2'd1,
    OpClear = 2'd2
  } op_e;

  typedef enum logic [FitW-1:0] {
    FitFirst = 2'd0,
    FitBest  = 2'd1,
    FitWorst = 2'd2
  } fit_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFitMode     = 2'd0,
    CfgBlocksInUse = 2'd1
  } cfg_idx_e;

endpackage

`default_nettype wire

[sv/fixed_partition_fit_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Partition table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every item gives one
// result, strobed by result_valid_o for a single cycle, which the receiver
// must take as it comes. A load, or an unknown operation, strobes its result
// in the cycle after the transfer. An allocate walks the table one entry per
// cycle through a single compare unit over the first min(blocks_in_use, 16)
// entries (first fit stops at the first hit), then passes an update state;
// its result is strobed in the cycle after that state. With no blocks in use
// the miss is strobed in the cycle after the transfer. A clear restores the
// free space of all 16 entries, one entry per cycle, strobing its result with
// the last entry. busy is high during a scan, an update or a clear.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_partition_fit_allocator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [fpfa_pkg::OpW-1:0]          operation_i,
  input  wire logic [fpfa_pkg::BlockW-1:0]       block_index_i,
  input  wire logic [fpfa_pkg::SizeW-1:0]        size_value_i,
  input  wire logic [fpfa_pkg::OwnerW-1:0]       owner_id_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [fpfa_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [fpfa_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output logic                                   result_valid_o,
  output logic                                   granted_o,
  output logic [fpfa_pkg::BlockW-1:0]            chosen_block_o,
  output logic [fpfa_pkg::SizeW-1:0]             space_left_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate,
    StClear
  } state_e;

  state_e                                       state_q;
  logic [fpfa_pkg::FitW-1:0]                    fit_mode_q;
  logic [fpfa_pkg::InUseW-1:0]                  in_use_q;

  logic [fpfa_pkg::SizeW-1:0]                   size_q  [fpfa_pkg::NumBlocks];
  logic [fpfa_pkg::SizeW-1:0]                   free_q  [fpfa_pkg::NumBlocks];
  logic [fpfa_pkg::OwnerW-1:0]                  owner_q [fpfa_pkg::NumBlocks];
  logic [fpfa_pkg::NumBlocks-1:0]               owned_q;

  logic [fpfa_pkg::SizeW-1:0]                   req_q;
  logic [fpfa_pkg::OwnerW-1:0]                  req_owner_q;
  logic [fpfa_pkg::CntW-1:0]                    cnt_q;
  logic [fpfa_pkg::CntW-1:0]                    limit_q;
  logic [fpfa_pkg::BlkIdxW-1:0]                 pick_q;
  logic                                         found_q;
  logic [fpfa_pkg::SizeW-1:0]                   best_q;

  logic                                         accept;
  logic [fpfa_pkg::CntW-1:0]                    limit;
  logic [fpfa_pkg::BlkIdxW-1:0]                 cur_idx;
  logic [fpfa_pkg::BlkIdxW-1:0]                 load_idx;
  logic [fpfa_pkg::SizeW-1:0]                   cur_size;
  logic                                         qualify;
  logic                                         take;
  logic                                         last;
  logic [fpfa_pkg::CntW-1:0]                    cnt_next;
  logic [fpfa_pkg::SizeW-1:0]                   pick_free;
  logic [fpfa_pkg::SizeW-1:0]                   left;

  assign busy     = (state_q != StIdle);
  assign accept   = start && !busy;
  assign cur_idx  = cnt_q[fpfa_pkg::BlkIdxW-1:0];
  assign load_idx = fpfa_pkg::BlkIdxW'(block_index_i);
  assign cur_size = size_q[cur_idx];
  assign cnt_next = cnt_q + fpfa_pkg::CntW'(1);
  assign last     = (cnt_next == limit_q);

  // searches never go past the table
  always_comb begin
    if (int'(in_use_q) > fpfa_pkg::NumBlocks) begin
      limit = fpfa_pkg::CntW'(fpfa_pkg::NumBlocks);
    end else begin
      limit = fpfa_pkg::CntW'(in_use_q);
    end
  end

  // the shared compare unit
  always_comb begin
    qualify = !owned_q[cur_idx] && (cur_size >= req_q);
    case (fpfa_pkg::fit_e'(fit_mode_q))
      fpfa_pkg::FitBest:  take = qualify && (!found_q || (cur_size < best_q));
      fpfa_pkg::FitWorst: take = qualify && (cur_size > (found_q ? best_q : '0));
      default:            take = qualify;
    endcase
  end

  assign pick_free = free_q[pick_q];
  assign left      = (pick_free >= req_q) ? (pick_free - req_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= '0;
      in_use_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fpfa_pkg::CfgFitMode:     fit_mode_q <= fpfa_pkg::FitW'(cfg_wdata_i);
        fpfa_pkg::CfgBlocksInUse: in_use_q   <= fpfa_pkg::InUseW'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      owned_q        <= '0;
      req_q          <= '0;
      req_owner_q    <= '0;
      cnt_q          <= '0;
      limit_q        <= '0;
      pick_q         <= '0;
      found_q        <= 1'b0;
      best_q         <= '0;
      result_valid_o <= 1'b0;
      granted_o      <= 1'b0;
      chosen_block_o <= '0;
      space_left_o   <= '0;
      for (int i = 0; i < fpfa_pkg::NumBlocks; i++) begin
        size_q[i]  <= '0;
        free_q[i]  <= '0;
        owner_q[i] <= '0;
      end
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            granted_o      <= 1'b0;
            chosen_block_o <= '0;
            space_left_o   <= '0;
            req_q          <= size_value_i;
            req_owner_q    <= owner_id_i;
            cnt_q          <= '0;
            limit_q        <= limit;
            found_q        <= 1'b0;
            case (operation_i)
              fpfa_pkg::OpLoad: begin
                if (int'(block_index_i) < fpfa_pkg::NumBlocks) begin
                  size_q[load_idx]  <= size_value_i;
                  free_q[load_idx]  <= size_value_i;
                  owned_q[load_idx] <= 1'b0;
                end
                result_valid_o <= 1'b1;
              end
              fpfa_pkg::OpAlloc: begin
                if (limit == '0) begin
                  result_valid_o <= 1'b1;
                end else begin
                  state_q <= StScan;
                end
              end
              fpfa_pkg::OpClear: begin
                owned_q <= '0;
                state_q <= StClear;
              end
              default: begin
                result_valid_o <= 1'b1;
              end
            endcase
          end
        end
        StScan: begin
          if (take) begin
            found_q <= 1'b1;
            pick_q  <= cur_idx;
            best_q  <= cur_size;
          end
          cnt_q <= cnt_next;
          if (last || (take && (fit_mode_q != fpfa_pkg::FitBest)
                           && (fit_mode_q != fpfa_pkg::FitWorst))) begin
            state_q <= StUpdate;
          end
        end
        StUpdate: begin
          if (found_q) begin
            owned_q[pick_q] <= 1'b1;
            owner_q[pick_q] <= req_owner_q;
            free_q[pick_q]  <= left;
            granted_o       <= 1'b1;
            chosen_block_o  <= fpfa_pkg::BlockW'(pick_q);
            space_left_o    <= left;
          end
          result_valid_o <= 1'b1;
          state_q        <= StIdle;
        end
        StClear: begin
          free_q[cur_idx] <= cur_size;
          cnt_q           <= cnt_next;
          if (cnt_next == fpfa_pkg::CntW'(fpfa_pkg::NumBlocks)) begin
            result_valid_o <= 1'b1;
            state_q        <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire
